### rtl/mrfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrfd_pkg
// Types, constants and the CRC byte update shared by the reply frame decoder.
// ----------------------------------------------------------------------------
package mrfd_pkg;

	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [5:0]  LEN_MIN     = 6'd4;
	localparam logic [5:0]  LEN_MAX     = 6'd32;
	localparam logic [5:0]  LEN_RESET   = 6'd19;
	localparam logic [7:0]  NIBBLE_MASK = 8'h0F;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_FRAME_LENGTH = 1'b0,
		CFG_VALUE_LAYOUT = 1'b1
	} cfg_index_t;

	typedef enum logic [0:0] {
		LAYOUT_READING = 1'b0,
		LAYOUT_ENERGY  = 1'b1
	} layout_t;

	typedef logic [7:0] byte_t;

	// One byte through the reflected CRC-16/Modbus, eight shift steps.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input byte_t b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### rtl/mrfd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrfd_in_if
// Byte stream channel into the reply frame decoder.
// ----------------------------------------------------------------------------
interface mrfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface
`default_nettype wire

### rtl/mrfd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrfd_out_if
// Result channel out of the reply frame decoder.
// ----------------------------------------------------------------------------
interface mrfd_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] reading;
	logic        crc_good;

	modport source (output valid, output reading, output crc_good, input ready);
	modport sink   (input valid, input reading, input crc_good, output ready);
endinterface
`default_nettype wire

### rtl/meter_reply_frame_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// meter_reply_frame_decoder
// Runs CRC-16/Modbus over reply bytes and extracts the meter value when the
// configured frame length is reached.
// ----------------------------------------------------------------------------
// A frame's last byte is held in the input register, its result then in the
// result register. Throughput: one byte per cycle while the result register is free
// or being emptied; the eight-step CRC network between them sets the cycle time.
// Reset: asynchronous, clears the frame state (CRC to 0xFFFF, count and payload
// bytes to zero), the configuration to its defaults and both valid flags.
module meter_reply_frame_decoder
	import mrfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [5:0] cfg_data,
	mrfd_in_if.sink         rx,
	mrfd_out_if.source      res
);

	logic [5:0]  frame_length_q;
	layout_t     value_layout_q;

	logic        valid_s1;
	byte_t       byte_s1;
	logic        start_s1;

	logic [15:0] crc_q;
	logic [5:0]  count_q;
	byte_t       pay_q [4];

	logic        res_valid_q;
	logic [23:0] reading_q;
	logic        crc_good_q;

	logic        advance;
	logic [5:0]  len_use;
	logic [5:0]  cnt_base;
	logic [5:0]  cnt_m1;
	logic [15:0] crc_base;
	logic [15:0] crc_n;
	logic [5:0]  cnt_n;
	byte_t       pay_n [4];
	logic        take;
	logic        done;
	logic [23:0] reading_n;

	// The stage moves whenever the result register is free or being emptied.
	assign advance  = !res_valid_q || res.ready;
	assign rx.ready = !valid_s1 || advance;

	always_comb begin
		if (frame_length_q < LEN_MIN) begin
			len_use = LEN_MIN;
		end else if (frame_length_q > LEN_MAX) begin
			len_use = LEN_MAX;
		end else begin
			len_use = frame_length_q;
		end
	end

	always_comb begin
		cnt_base = start_s1 ? 6'd0 : count_q;
		crc_base = start_s1 ? CRC_INIT : crc_q;
		for (int i = 0; i < 4; i++) begin
			pay_n[i] = start_s1 ? 8'h00 : pay_q[i];
		end
		cnt_m1 = cnt_base - 6'd1;
		take   = cnt_base < len_use;
		crc_n  = crc_base;
		cnt_n  = cnt_base;
		if (take) begin
			crc_n = crc_feed(crc_base, byte_s1);
			cnt_n = cnt_base + 6'd1;
			if (cnt_base >= 6'd1 && cnt_base <= 6'd4) begin
				pay_n[cnt_m1[1:0]] = byte_s1;
			end
		end
		done = take && (cnt_n == len_use);
		if (value_layout_q == LAYOUT_READING) begin
			reading_n = {pay_n[0] & NIBBLE_MASK, pay_n[2], pay_n[1]};
		end else begin
			reading_n = {pay_n[0], pay_n[3], pay_n[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= LEN_RESET;
			value_layout_q <= LAYOUT_READING;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_FRAME_LENGTH: frame_length_q <= cfg_data;
				CFG_VALUE_LAYOUT: value_layout_q <= layout_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1  <= rx.rx_byte;
			start_s1 <= rx.frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			count_q <= 6'd0;
			for (int i = 0; i < 4; i++) begin
				pay_q[i] <= 8'h00;
			end
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && done;
			if (valid_s1) begin
				crc_q   <= crc_n;
				count_q <= cnt_n;
				for (int i = 0; i < 4; i++) begin
					pay_q[i] <= pay_n[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && done) begin
			reading_q  <= reading_n;
			crc_good_q <= (crc_n == 16'h0000);
		end
	end

	assign res.valid    = res_valid_q;
	assign res.reading  = reading_q;
	assign res.crc_good = crc_good_q;

endmodule
`default_nettype wire

### test/meter_reply_frame_checker.sv
// ----------------------------------------------------------------------------
// meter_reply_frame_checker
// Watches the byte and result channels of the reply frame decoder. It keeps
// its own CRC-16/Modbus state, byte count, payload bytes and configuration,
// predicts the result of every completed frame, and compares each result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module meter_reply_frame_checker
	import mrfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [5:0] cfg_data,
	mrfd_in_if              rx,
	mrfd_out_if             res,
	output int              mismatches,
	output int              outstanding
);

	typedef struct packed {
		logic [23:0] reading;
		logic        crc_good;
	} reply_t;

	logic [15:0] crc;
	logic [5:0]  nbytes;
	byte_t       payload [4];
	logic [5:0]  frame_length;
	layout_t     layout;
	reply_t      expected_replies [$];

	// Bit-serial form: each data bit, LSB first, is folded into the feedback.
	function automatic logic [15:0] crc_next(input logic [15:0] c, input byte_t b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic logic [5:0] length_in_use();
		if (frame_length < LEN_MIN) begin
			return LEN_MIN;
		end else if (frame_length > LEN_MAX) begin
			return LEN_MAX;
		end
		return frame_length;
	endfunction

	task automatic clear_frame();
		crc = CRC_INIT;
		nbytes = '0;
		foreach (payload[i]) payload[i] = '0;
	endtask

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: mismatch: %s", $realtime, msg);
		end
	endtask

	task automatic check_reply();
		reply_t want;
		if (expected_replies.size() == 0) begin
			flag($sformatf("result with none pending: reading %h crc_good %b",
				res.reading, res.crc_good));
		end else begin
			want = expected_replies.pop_front();
			if (res.reading !== want.reading) begin
				flag($sformatf("reading expected %h, got %h", want.reading, res.reading));
			end
			if (res.crc_good !== want.crc_good) begin
				flag($sformatf("crc_good expected %b, got %b", want.crc_good, res.crc_good));
			end
		end
	endtask

	task automatic take_byte(input byte_t b, input logic start);
		reply_t want;
		if (start) begin
			clear_frame();
		end
		// Once the count has reached the length in use, bytes without a frame
		// start are dropped without touching any state.
		if (nbytes < length_in_use()) begin
			crc = crc_next(crc, b);
			if (nbytes >= 6'd1 && nbytes <= 6'd4) begin
				payload[nbytes[1:0] - 2'd1] = b;
			end
			nbytes = nbytes + 6'd1;
			if (nbytes == length_in_use()) begin
				if (layout == LAYOUT_READING) begin
					want.reading = {payload[0] & NIBBLE_MASK, payload[2], payload[1]};
				end else begin
					want.reading = {payload[0], payload[3], payload[2]};
				end
				want.crc_good = (crc == 16'h0000);
				expected_replies.push_back(want);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			frame_length = LEN_RESET;
			layout = LAYOUT_READING;
			expected_replies.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (res.valid && res.ready) begin
				check_reply();
			end
			if (cfg_we) begin
				if (cfg_index == CFG_FRAME_LENGTH) begin
					frame_length = cfg_data;
				end else begin
					layout = layout_t'(cfg_data[0]);
				end
			end
			if (rx.valid && rx.ready) begin
				take_byte(rx.rx_byte, rx.frame_start);
			end
			outstanding = expected_replies.size();
		end
	end

endmodule

### test/meter_reply_frame_decoder_test.sv
// ----------------------------------------------------------------------------
// meter_reply_frame_decoder_test
// Drives reply bytes and configuration into the frame decoder: a directed
// opening for the corner cases, then phases of random settings with mostly
// well-formed frames carrying a valid CRC, mixed with corrupted, truncated,
// overlong and noise sequences. Both channels idle at random. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module meter_reply_frame_decoder_test;
	import mrfd_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [5:0] cfg_data;
	int         mismatches;
	int         outstanding;
	bit         send_gaps;
	bit         take_gaps;
	int         cur_len;
	int         bytes_fed;

	mrfd_in_if  rx ();
	mrfd_out_if res ();

	meter_reply_frame_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx),
		.res       (res)
	);

	meter_reply_frame_checker replies (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rx          (rx),
		.res         (res),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	function automatic byte_t rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [5:0] pick_length();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 13) begin
			return 6'($urandom_range(4, 12));
		end else if (pick < 15) begin
			return 6'($urandom_range(0, 3));
		end else if (pick < 17) begin
			return 6'($urandom_range(33, 63));
		end else if (pick == 17) begin
			return LEN_MAX;
		end
		return 6'($urandom_range(13, 31));
	endfunction

	function automatic logic [15:0] modbus_crc(input byte_t bytes [$]);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (bytes[i]) begin
			c ^= {8'h00, bytes[i]};
			repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Leaves valid high after the transfer so back-to-back bytes need no gap.
	task automatic send_byte(input byte_t value, input logic first);
		int gap;
		gap = send_gaps ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= value;
		rx.frame_start <= first;
		do @(posedge clk); while (!rx.ready);
	endtask

	// The CRC goes out low byte first, so a clean frame leaves a zero residue.
	task automatic send_frame(input int n, input bit corrupt);
		byte_t       bytes [$];
		logic [15:0] crc;
		for (int i = 0; i < n - 2; i++) bytes.push_back(rand_byte());
		crc = modbus_crc(bytes);
		bytes.push_back(crc[7:0]);
		bytes.push_back(crc[15:8]);
		if (corrupt) begin
			bytes[$urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
		end
		foreach (bytes[i]) send_byte(bytes[i], i == 0);
		bytes_fed += n;
	endtask

	task automatic drain();
		rx.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_config(input logic [5:0] length, input layout_t layout);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FRAME_LENGTH;
		cfg_data <= length;
		@(posedge clk);
		cfg_index <= CFG_VALUE_LAYOUT;
		cfg_data <= {5'($urandom), layout};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (length < LEN_MIN) begin
			cur_len = LEN_MIN;
		end else if (length > LEN_MAX) begin
			cur_len = LEN_MAX;
		end else begin
			cur_len = length;
		end
	endtask

	initial begin
		int stall;
		res.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = take_gaps ? $urandom_range(0, 8) : 0;
			if (stall != 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!(res.valid && res.ready));
		end
	end

	initial begin
		int pick;
		int cut;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_FRAME_LENGTH;
		cfg_data <= '0;
		rx.valid <= 1'b0;
		rx.rx_byte <= '0;
		rx.frame_start <= 1'b0;
		send_gaps = 1'b1;
		take_gaps = 1'b1;
		bytes_fed = 0;
		cur_len = LEN_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes with no frame start after reset count as a frame begun at reset;
		// the two after completion must be dropped.
		write_config(6'd4, LAYOUT_READING);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		drain();
		// A zero length saturates to four, so byte 4 is never reached.
		write_config(6'd0, LAYOUT_ENERGY);
		send_frame(4, 1'b0);
		drain();
		write_config(6'd5, LAYOUT_ENERGY);
		send_frame(5, 1'b0);
		drain();
		write_config(6'd8, LAYOUT_READING);
		send_byte(8'h00, 1'b1);
		repeat (4) send_byte(8'hFF, 1'b0);
		drain();
		// Lowering the length below the count strands the open frame.
		write_config(6'd4, LAYOUT_ENERGY);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_frame(4, 1'b1);
		drain();

		while (bytes_fed < 1900) begin
			write_config(pick_length(), layout_t'($urandom_range(0, 1)));
			send_gaps = $urandom_range(0, 3) != 0;
			take_gaps = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(2, 8)) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					send_frame(cur_len, 1'b0);
				end else if (pick < 72) begin
					send_frame(cur_len, 1'b1);
				end else if (pick < 84) begin
					cut = $urandom_range(1, cur_len - 1);
					for (int i = 0; i < cut; i++) send_byte(rand_byte(), i == 0);
					bytes_fed += cut;
				end else if (pick < 92) begin
					cut = $urandom_range(1, cur_len + 4);
					repeat (cut) send_byte(rand_byte(), $urandom_range(0, 7) == 0);
					bytes_fed += cut;
				end else begin
					send_frame(cur_len, 1'b0);
					repeat ($urandom_range(1, 3)) send_byte(rand_byte(), 1'b0);
				end
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("PASS meter_reply_frame_decoder");
		end else begin
			$display("FAIL meter_reply_frame_decoder");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL meter_reply_frame_decoder");
		$finish;
	end

endmodule
